FILE: sv/vdlt2_pkg.sv
package vdlt2_pkg;

  // Field widths fixed by the item format
  localparam int unsigned VALUE_W = 24;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned COUNT_W = 2;

  // Q7.16 constants
  localparam logic signed [VALUE_W-1:0] FIXED_ONE = 24'sd65536;
  localparam logic signed [VALUE_W-1:0] THR_RESET = -24'sd65536;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sh7FFFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 24'sh800000;

  // Action codes
  localparam logic ACT_ACCUM   = 1'b0;
  localparam logic ACT_CORRECT = 1'b1;

  // Register indexes
  localparam logic REG_THRESHOLD = 1'b0;

  // Record fill levels
  localparam logic [COUNT_W-1:0] CNT_EMPTY = 2'd0;
  localparam logic [COUNT_W-1:0] CNT_ONE   = 2'd1;
  localparam logic [COUNT_W-1:0] CNT_TWO   = 2'd2;

  typedef struct packed {
    logic                      action;
    logic [INDEX_W-1:0]        voxel_index;
    logic [LABEL_W-1:0]        label_id;
    logic signed [VALUE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_W-1:0]        dominant_label;
    logic signed [VALUE_W-1:0] corrected_value;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] best_value;
    logic [LABEL_W-1:0]        best_label;
    logic signed [VALUE_W-1:0] second_value;
    logic [LABEL_W-1:0]        second_label;
  } rec_t;

  // Record update status from the update logic to the top level
  typedef struct packed {
    logic wr_en;
    logic has_result;
  } upd_ctl_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

FILE: sv/vdlt2_rec_upd.sv
module vdlt2_rec_upd (
  input  vdlt2_pkg::in_item_t                   item,
  input  logic                                  in_range,
  input  logic signed [vdlt2_pkg::VALUE_W-1:0]  threshold,
  input  vdlt2_pkg::rec_t                       rec,
  output vdlt2_pkg::rec_t                       rec_nxt,
  output vdlt2_pkg::out_item_t                  result,
  output vdlt2_pkg::upd_ctl_t                   ctl
);

  logic                                   above_best;
  logic                                   above_second;
  logic                                   present;
  logic [vdlt2_pkg::COUNT_W-1:0]          cnt;
  logic signed [vdlt2_pkg::VALUE_W:0]     diff;
  logic signed [vdlt2_pkg::VALUE_W-1:0]   s;

  assign s = item.sample_value;

  // Rank the new pair against the held pairs
  assign above_best = ($signed(s) > $signed(rec.best_value)) ||
                      ((s == rec.best_value) && (item.label_id < rec.best_label));
  assign above_second = ($signed(s) > $signed(rec.second_value)) ||
                        ((s == rec.second_value) && (item.label_id < rec.second_label));
  assign present = $signed(s) > $signed(threshold);

  // Insert the pair into the record
  always_comb begin
    rec_nxt        = rec;
    ctl.wr_en      = 1'b0;
    ctl.has_result = (item.action == vdlt2_pkg::ACT_CORRECT);
    if ((item.action == vdlt2_pkg::ACT_ACCUM) && in_range && present) begin
      ctl.wr_en = 1'b1;
      if (rec.count == vdlt2_pkg::CNT_EMPTY) begin
        rec_nxt.best_value = s;
        rec_nxt.best_label = item.label_id;
        rec_nxt.count      = vdlt2_pkg::CNT_ONE;
      end else if (above_best) begin
        rec_nxt.second_value = rec.best_value;
        rec_nxt.second_label = rec.best_label;
        rec_nxt.best_value   = s;
        rec_nxt.best_label   = item.label_id;
        rec_nxt.count        = vdlt2_pkg::CNT_TWO;
      end else if ((rec.count == vdlt2_pkg::CNT_ONE) || above_second) begin
        rec_nxt.second_value = s;
        rec_nxt.second_label = item.label_id;
        rec_nxt.count        = vdlt2_pkg::CNT_TWO;
      end
    end
  end

  // Pick the competing value and correct the sample
  always_comb begin
    cnt = in_range ? rec.count : vdlt2_pkg::CNT_EMPTY;
    result.dominant_label = '0;
    case (cnt)
      vdlt2_pkg::CNT_EMPTY: begin
        diff = 25'(s) + 25'(vdlt2_pkg::FIXED_ONE);
      end
      vdlt2_pkg::CNT_ONE: begin
        result.dominant_label = rec.best_label;
        diff = (item.label_id == rec.best_label) ?
               25'(s) + 25'(vdlt2_pkg::FIXED_ONE) :
               25'(s) - 25'(rec.best_value);
      end
      default: begin
        result.dominant_label = rec.best_label;
        diff = (item.label_id == rec.best_label) ?
               25'(s) - 25'(rec.second_value) :
               25'(s) - 25'(rec.best_value);
      end
    endcase
    result.saturated = diff[vdlt2_pkg::VALUE_W] ^ diff[vdlt2_pkg::VALUE_W-1];
    if (result.saturated) begin
      result.corrected_value = diff[vdlt2_pkg::VALUE_W] ? vdlt2_pkg::VALUE_MIN :
                                                          vdlt2_pkg::VALUE_MAX;
    end else begin
      result.corrected_value = diff[vdlt2_pkg::VALUE_W-1:0];
    end
  end

endmodule

FILE: sv/voxel_dominant_label_top2_unit.sv
// Per-voxel top-two label tracker. Each voxel has one record (best and
// second-best value/label pairs plus a fill count) in a simple dual-port
// memory with a registered read. A record is read at acceptance, updated
// from the read register and written back as the request leaves stage 1,
// and the last write is forwarded, so items stream at one per cycle while
// input is not stalled; a correct request's result is loaded into the output
// register as it leaves stage 1. After reset the block sweeps the record
// memory, one entry per cycle, clearing fill counts: requests are held off
// until the sweep ends; threshold writes are taken throughout. After the sweep
// the block only stalls input when a correct request is waiting behind a stalled result.
module voxel_dominant_label_top2_unit #(
  parameter int unsigned VOXEL_COUNT = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  vdlt2_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output vdlt2_pkg::out_item_t  out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned AW = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(VOXEL_COUNT - 1);

  vdlt2_pkg::state_t state_r, state_nxt;
  logic              clearing;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  logic signed [vdlt2_pkg::VALUE_W-1:0] thr_r, thr_nxt;

  logic                 s1_v_r, s1_v_nxt;
  vdlt2_pkg::in_item_t  s1_item_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_range_r;
  logic                 s1_adv;
  logic                 in_accept;

  vdlt2_pkg::rec_t      mem [VOXEL_COUNT];
  vdlt2_pkg::rec_t      rd_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  vdlt2_pkg::rec_t      mem_wd;

  logic                 fwd_v_r, fwd_v_nxt;
  logic [AW-1:0]        fwd_addr_r;
  vdlt2_pkg::rec_t      fwd_rec_r;

  vdlt2_pkg::rec_t      cur_rec;
  vdlt2_pkg::rec_t      upd_rec;
  vdlt2_pkg::out_item_t upd_res;
  vdlt2_pkg::upd_ctl_t  upd_ctl;

  logic                 out_valid_r, out_valid_nxt;
  vdlt2_pkg::out_item_t out_data_r;
  logic                 out_load;

  // Next state: sweep the memory, then run
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vdlt2_pkg::ST_CLEAR: if (clr_addr_r == LAST_ADDR) state_nxt = vdlt2_pkg::ST_RUN;
      vdlt2_pkg::ST_RUN:   state_nxt = vdlt2_pkg::ST_RUN;
      default:             state_nxt = vdlt2_pkg::ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    case (state_r)
      vdlt2_pkg::ST_CLEAR: clearing = 1'b1;
      default:             clearing = 1'b0;
    endcase
  end

  assign clr_addr_nxt = clearing ? clr_addr_r + AW'(1) : clr_addr_r;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == vdlt2_pkg::REG_THRESHOLD) ? 32'(thr_r) : 32'd0;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        (cfg_paddr[2] == vdlt2_pkg::REG_THRESHOLD)) begin
      thr_nxt = cfg_pwdata[vdlt2_pkg::VALUE_W-1:0];
    end
  end

  // Hold stage 1 only when its result cannot be handed on
  assign s1_adv    = !(s1_v_r && upd_ctl.has_result && out_valid_r && out_stall);
  assign in_stall  = clearing || !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign s1_v_nxt  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  // Take the freshest copy of the record
  assign cur_rec = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_rec_r : rd_r;

  vdlt2_rec_upd u_upd (
    .item      (s1_item_r),
    .in_range  (s1_range_r),
    .threshold (thr_r),
    .rec       (cur_rec),
    .rec_nxt   (upd_rec),
    .result    (upd_res),
    .ctl       (upd_ctl)
  );

  // Write back the updated record, or clear during the sweep
  always_comb begin
    if (clearing) begin
      mem_we       = 1'b1;
      mem_wa       = clr_addr_r;
      mem_wd       = '0;
      mem_wd.count = vdlt2_pkg::CNT_EMPTY;
    end else begin
      mem_we = s1_v_r && s1_adv && upd_ctl.wr_en;
      mem_wa = s1_addr_r;
      mem_wd = upd_rec;
    end
  end

  assign fwd_v_nxt = clearing ? 1'b0 : (mem_we ? 1'b1 : fwd_v_r);

  // Load the result register
  assign out_load      = s1_v_r && s1_adv && upd_ctl.has_result;
  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // Record memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_accept) begin
      rd_r <= mem[AW'(in_data.voxel_index)];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vdlt2_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      thr_r       <= vdlt2_pkg::THR_RESET;
      s1_v_r      <= 1'b0;
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      thr_r       <= thr_nxt;
      s1_v_r      <= s1_v_nxt;
      fwd_v_r     <= fwd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r  <= in_data;
      s1_addr_r  <= AW'(in_data.voxel_index);
      s1_range_r <= 32'(in_data.voxel_index) < 32'(VOXEL_COUNT);
    end
    if (mem_we && !clearing) begin
      fwd_addr_r <= mem_wa;
      fwd_rec_r  <= mem_wd;
    end
    if (out_load) begin
      out_data_r <= upd_res;
    end
  end

  // No request enters while the sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> state_r == vdlt2_pkg::ST_RUN)
    else $error("request accepted during memory clear");

  // Run-time writes come only from a live accumulate request
  a_write_from_accum: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !clearing) |-> (s1_v_r && s1_item_r.action == vdlt2_pkg::ACT_ACCUM))
    else $error("record write without accumulate request");

  // The forward register tracks the last run-time write
  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !clearing) |=> (fwd_v_r && fwd_addr_r == $past(mem_wa)))
    else $error("forward register lost last write");

  // A written record never holds more than two pairs
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> mem_wd.count != 2'd3)
    else $error("record count out of range");

  // A waiting result is not overwritten
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("pending result overwritten");

endmodule

FILE: test/voxel_dominant_label_top2_unit_test.sv
`timescale 1ns / 1ps

module voxel_dominant_label_top2_unit_test;

  localparam int unsigned VOXELS = 65536;
  // write-back lands as the request leaves stage 1; give accumulates time to land
  localparam int unsigned SETTLE_CYCLES = 4;
  // the clearing sweep after reset is the longest quiet stretch
  localparam int unsigned STALL_LIMIT = 4 * VOXELS;
  localparam int unsigned PRINT_CAP = 40;
  localparam logic [2:0] ADDR_THRESHOLD = 3'(4 * int'(vdlt2_pkg::REG_THRESHOLD));

  typedef struct {
    logic [vdlt2_pkg::COUNT_W-1:0]        fill;
    logic signed [vdlt2_pkg::VALUE_W-1:0] top_value;
    logic [vdlt2_pkg::LABEL_W-1:0]        top_label;
    logic signed [vdlt2_pkg::VALUE_W-1:0] next_value;
    logic [vdlt2_pkg::LABEL_W-1:0]        next_label;
  } voxel_entry_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  vdlt2_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  vdlt2_pkg::out_item_t out_data;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [2:0]           cfg_paddr = '0;
  logic [31:0]          cfg_pwdata = '0;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  // shadow of the voxel store and the threshold register
  voxel_entry_t                         voxel_records[int unsigned];
  logic signed [vdlt2_pkg::VALUE_W-1:0] threshold_q = vdlt2_pkg::THR_RESET;
  vdlt2_pkg::out_item_t                 pending_corrections[$];
  logic [vdlt2_pkg::INDEX_W-1:0]        voxel_pool[6];

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          fails = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          saturations_seen = 0;
  int unsigned quiet_cycles = 0;

  voxel_dominant_label_top2_unit #(
    .VOXEL_COUNT(VOXELS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fails++;
    if (fails <= PRINT_CAP)
      $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic voxel_entry_t fetch_record(input int unsigned idx);
    voxel_entry_t rec;
    rec = '{vdlt2_pkg::CNT_EMPTY, '0, '0, '0, '0};
    if (voxel_records.exists(idx))
      rec = voxel_records[idx];
    return rec;
  endfunction

  // higher value first, lower label breaks a tie
  function automatic bit outranks(input longint va,
                                  input logic [vdlt2_pkg::LABEL_W-1:0] la,
                                  input longint vb,
                                  input logic [vdlt2_pkg::LABEL_W-1:0] lb);
    return (va > vb) || (va == vb && la < lb);
  endfunction

  // Update the shadow record; return 1 with the expected correction if one is due
  function automatic bit update_and_correct(input vdlt2_pkg::in_item_t req,
                                            output vdlt2_pkg::out_item_t res);
    voxel_entry_t rec;
    longint       sample;
    longint       corr;
    int unsigned  idx;
    idx = 32'(req.voxel_index);
    rec = fetch_record(idx);
    sample = longint'($signed(req.sample_value));
    res = '0;
    if (req.action == vdlt2_pkg::ACT_ACCUM) begin
      if (idx < VOXELS && sample > longint'(threshold_q)) begin
        if (rec.fill == vdlt2_pkg::CNT_EMPTY) begin
          rec.top_value = req.sample_value;
          rec.top_label = req.label_id;
          rec.fill = vdlt2_pkg::CNT_ONE;
        end else if (outranks(sample, req.label_id, rec.top_value, rec.top_label)) begin
          rec.next_value = rec.top_value;
          rec.next_label = rec.top_label;
          rec.top_value = req.sample_value;
          rec.top_label = req.label_id;
          rec.fill = vdlt2_pkg::CNT_TWO;
        end else if (rec.fill == vdlt2_pkg::CNT_ONE ||
                     outranks(sample, req.label_id, rec.next_value, rec.next_label)) begin
          rec.next_value = req.sample_value;
          rec.next_label = req.label_id;
          rec.fill = vdlt2_pkg::CNT_TWO;
        end
        voxel_records[idx] = rec;
      end
      return 1'b0;
    end
    if (idx >= VOXELS)
      rec.fill = vdlt2_pkg::CNT_EMPTY;
    if (rec.fill == vdlt2_pkg::CNT_EMPTY) begin
      corr = sample + longint'(vdlt2_pkg::FIXED_ONE);
    end else begin
      res.dominant_label = rec.top_label;
      if (req.label_id != rec.top_label)
        corr = sample - longint'(rec.top_value);
      else if (rec.fill == vdlt2_pkg::CNT_ONE)
        corr = sample + longint'(vdlt2_pkg::FIXED_ONE);
      else
        corr = sample - longint'(rec.next_value);
    end
    // clamp to the Q7.16 range
    if (corr > longint'(vdlt2_pkg::VALUE_MAX)) begin
      corr = longint'(vdlt2_pkg::VALUE_MAX);
      res.saturated = 1'b1;
    end else if (corr < longint'(vdlt2_pkg::VALUE_MIN)) begin
      corr = longint'(vdlt2_pkg::VALUE_MIN);
      res.saturated = 1'b1;
    end
    res.corrected_value = corr[vdlt2_pkg::VALUE_W-1:0];
    return 1'b1;
  endfunction

  function automatic vdlt2_pkg::in_item_t make_request(
      input logic act, input logic [vdlt2_pkg::INDEX_W-1:0] vox,
      input logic [vdlt2_pkg::LABEL_W-1:0] lab,
      input logic [vdlt2_pkg::VALUE_W-1:0] val);
    return '{act, vox, lab, val};
  endfunction

  function automatic logic [vdlt2_pkg::VALUE_W-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)
      return vdlt2_pkg::VALUE_W'(int'($urandom_range(524288)) - 262144);
    // coarse grid so equal values come up often
    if (pick < 70)
      return vdlt2_pkg::VALUE_W'((int'($urandom_range(16)) - 8) * 32768);
    if (pick < 90)
      return vdlt2_pkg::VALUE_W'($urandom());
    if (pick < 95)
      return vdlt2_pkg::VALUE_MAX;
    return vdlt2_pkg::VALUE_MIN;
  endfunction

  // Build a request on the current voxel pool, aiming corrections at held labels
  function automatic vdlt2_pkg::in_item_t random_request();
    vdlt2_pkg::in_item_t req;
    voxel_entry_t        rec;
    req.voxel_index = voxel_pool[$urandom_range(5)];
    req.sample_value = random_value();
    req.action = ($urandom_range(99) < 55) ? vdlt2_pkg::ACT_ACCUM : vdlt2_pkg::ACT_CORRECT;
    rec = fetch_record(32'(req.voxel_index));
    if (req.action == vdlt2_pkg::ACT_CORRECT && rec.fill != vdlt2_pkg::CNT_EMPTY &&
        $urandom_range(1) == 1)
      req.label_id = ($urandom_range(3) == 0 && rec.fill == vdlt2_pkg::CNT_TWO) ?
                     rec.next_label : rec.top_label;
    else if ($urandom_range(2) == 0)
      req.label_id = vdlt2_pkg::LABEL_W'($urandom_range(3));
    else
      req.label_id = vdlt2_pkg::LABEL_W'($urandom());
    return req;
  endfunction

  // Drive one request, hold it until taken, then predict its outcome
  task automatic send_request(input vdlt2_pkg::in_item_t req);
    vdlt2_pkg::out_item_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
    if (update_and_correct(req, res))
      pending_corrections.push_back(res);
  endtask

  // Hold off input until every expected result is back and write-back has settled
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_corrections.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_threshold(input logic [vdlt2_pkg::VALUE_W-1:0] value);
    logic [31:0] readback;
    apb_access(1'b1, ADDR_THRESHOLD,
               {{(32 - vdlt2_pkg::VALUE_W){value[vdlt2_pkg::VALUE_W-1]}}, value},
               readback);
    threshold_q = value;
    apb_access(1'b0, ADDR_THRESHOLD, '0, readback);
    if (readback[vdlt2_pkg::VALUE_W-1:0] !== value)
      report_mismatch("threshold readback", 64'(readback[vdlt2_pkg::VALUE_W-1:0]),
                      64'(value));
  endtask

  // Check each delivered result against the oldest prediction
  always @(posedge clk) begin
    vdlt2_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_corrections.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data), 64'd0);
      end else begin
        want = pending_corrections.pop_front();
        results_checked++;
        if (want.saturated)
          saturations_seen++;
        if (out_data.dominant_label !== want.dominant_label)
          report_mismatch("dominant_label", 64'(out_data.dominant_label),
                          64'(want.dominant_label));
        if (out_data.corrected_value !== want.corrected_value)
          report_mismatch("corrected_value", 64'(out_data.corrected_value),
                          64'(want.corrected_value));
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 64'(out_data.saturated), 64'(want.saturated));
      end
    end
  end

  // Stall the result side at the phase's rate
  always @(posedge clk)
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_corrections.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Corrections on never-written voxels, including the clamp at the top end
  task automatic test_empty_record();
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'h00,
                              vdlt2_pkg::VALUE_MAX));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'hFF,
                              vdlt2_pkg::VALUE_MIN));
    // exactly at the threshold: not recorded
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h0000, 8'd5, -24'sd65536));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'd5, 24'sd0));
  endtask

  // Insertion order, ties, displacement and the one- and two-entry corrections
  task automatic test_ranking();
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h0000, 8'd5, -24'sd65535));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'd5, 24'sd100));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'd9,
                              vdlt2_pkg::VALUE_MIN));
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h0000, 8'd7, 24'sh400000));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'd7, 24'sh000100));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'd3,
                              vdlt2_pkg::VALUE_MIN));
    // equal value, lower label takes the lead
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h0000, 8'd2, 24'sh400000));
    // below both: drop
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h0000, 8'd9, -24'sd1000));
    // ties the runner-up with a higher label: drop
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h0000, 8'd8, 24'sh400000));
    // ties the runner-up with a lower label: displace
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h0000, 8'd6, 24'sh400000));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'd2,
                              vdlt2_pkg::VALUE_MAX));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h0000, 8'd6, 24'sd0));
    // same label twice on one voxel
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'hFFFF, 8'hFF,
                              vdlt2_pkg::VALUE_MAX));
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'hFFFF, 8'hFF,
                              vdlt2_pkg::VALUE_MAX));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'hFFFF, 8'hFF,
                              vdlt2_pkg::VALUE_MIN));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'hFFFF, 8'h00,
                              vdlt2_pkg::VALUE_MAX));
  endtask

  // Threshold at both ends of its range
  task automatic test_threshold_extremes();
    wait_for_results();
    write_threshold(vdlt2_pkg::VALUE_MAX);
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h5A3C, 8'd1,
                              vdlt2_pkg::VALUE_MAX));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h5A3C, 8'd1, 24'sd0));
    wait_for_results();
    write_threshold(vdlt2_pkg::VALUE_MIN);
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h5A3C, 8'h80,
                              vdlt2_pkg::VALUE_MIN));
    send_request(make_request(vdlt2_pkg::ACT_ACCUM, 16'h5A3C, 8'h80,
                              vdlt2_pkg::VALUE_MIN + 24'sd1));
    send_request(make_request(vdlt2_pkg::ACT_CORRECT, 16'h5A3C, 8'h11,
                              vdlt2_pkg::VALUE_MAX));
  endtask

  task automatic run_traffic_phase(input int send_idle, input int recv_stall,
                                   input logic [vdlt2_pkg::VALUE_W-1:0] thr,
                                   input int count, input bit pause_midway);
    wait_for_results();
    write_threshold(thr);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    foreach (voxel_pool[i])
      voxel_pool[i] = vdlt2_pkg::INDEX_W'($urandom());
    for (int i = 0; i < count; i++) begin
      // let the pipeline run dry once mid-phase
      if (pause_midway && i == count / 2)
        wait_for_results();
      send_request(random_request());
    end
  endtask

  // Random traffic under each idling pattern and threshold setting
  task automatic test_random_traffic();
    run_traffic_phase(0, 0, vdlt2_pkg::THR_RESET, 160, 1'b0);
    run_traffic_phase(83, 0,
                      vdlt2_pkg::VALUE_W'(int'($urandom_range(262144)) - 131072),
                      160, 1'b1);
    run_traffic_phase(0, 83, vdlt2_pkg::VALUE_MIN, 160, 1'b0);
    run_traffic_phase(12, 12, vdlt2_pkg::THR_RESET, 160, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_record();
    test_ranking();
    test_threshold_extremes();
    test_random_traffic();
    wait_for_results();
    $display("Ran %0d requests through directed ranking, threshold extremes and four",
             requests_sent);
    $display("idling patterns; %0d corrections checked, %0d clamped, %0d mismatches",
             results_checked, saturations_seen, fails);
    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
